[src/sis_pkg.sv]
`timescale 1ns / 1ps

package sis_pkg;

    // Command codes carried on the command port
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Sequencer states: clear the sparse table after reset, then per command
    // fetch from both tables, then check and write back
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_CLEAR
    } t_state;

    localparam int ELEM_W  = 9;
    localparam int COUNT_W = 9;
    localparam int VALUE_W = 8;

endpackage

[src/sis_ram.sv]
`timescale 1ns / 1ps

module sis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read: data appears the cycle after the address
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/sparse_integer_set.sv]
`timescale 1ns / 1ps

// Sparse integer set over 0..UNIVERSE-1 (sparse index table, packed table, count).
//
// Command channel: drive i_command and i_element with start high; the command
// transfers at the rising edge where start is high and busy is low. busy stays
// high while the command is fetched and checked, so no new command is taken
// before the last one is through, as the two registered-read memories are read
// in turn: the sparse table gives the packed position, which then addresses
// the packed table, and the write back follows in the check cycle.
//
// Result channel: o_valid is registered from the check state and stays high
// for exactly one cycle, with o_was_member, o_member_count, o_read_value and
// o_status. The receiver cannot stall; a result not taken in that cycle is gone.
//
// Reset (i_rst_n low, synchronous) clears the count and starts a clearing pass
// that zeroes the sparse table, one entry per cycle; busy stays high until the
// last entry is cleared. The packed table is not cleared: only entries at
// positions below the count are used, and those were always written.
module sparse_integer_set #(
    parameter int UNIVERSE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [sis_pkg::ELEM_W-1:0]  i_element,
    output logic                        o_valid,
    output logic                        o_was_member,
    output logic [sis_pkg::COUNT_W-1:0] o_member_count,
    output logic [sis_pkg::VALUE_W-1:0] o_read_value,
    output logic                        o_status
);

    import sis_pkg::*;

    localparam int IDX_W = $clog2(UNIVERSE);
    localparam int CNT_W = $clog2(UNIVERSE + 1);

    // Sequencer and control
    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic [CNT_W-1:0] r_total, n_total;
    logic [IDX_W-1:0] r_clr_addr, n_clr_addr;

    // Command held for the duration of its work
    t_cmd              r_cmd;
    logic [ELEM_W-1:0] r_elem;

    // Fetched table data
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_moved, n_moved;

    // Result payload
    logic               r_was, n_was;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_status, n_status;

    // Memory ports
    logic             sp_we, sp_re, pk_we, pk_re;
    logic [IDX_W-1:0] sp_waddr, sp_wdata, sp_raddr, sp_rdata;
    logic [IDX_W-1:0] pk_waddr, pk_wdata, pk_raddr, pk_rdata;

    logic             w_accept;
    logic [31:0]      w_in32, w_elem32, w_total32, w_moved32, w_count32;
    logic [IDX_W-1:0] w_in_idx, w_elem_idx, w_last_idx, w_total_idx;
    logic             w_elem_ok, w_pos_ok, w_hit, w_is_mem, w_read_ok, w_full;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != ST_IDLE);

    assign w_in32      = 32'(i_element);
    assign w_elem32    = 32'(r_elem);
    assign w_total32   = 32'(r_total);
    assign w_moved32   = 32'(r_moved);
    assign w_in_idx    = w_in32[IDX_W-1:0];
    assign w_elem_idx  = w_elem32[IDX_W-1:0];
    assign w_total_idx = r_total[IDX_W-1:0];
    // Wraps when the set is empty; the fetched value is then never used
    assign w_last_idx  = w_total_idx - IDX_W'(1);

    // Membership check, valid in the check cycle
    assign w_elem_ok = (w_elem32 < 32'(UNIVERSE));
    assign w_pos_ok  = (32'(r_pos) < w_total32);
    assign w_hit     = (32'(pk_rdata) == w_elem32);
    assign w_is_mem  = w_elem_ok && w_pos_ok && w_hit;
    assign w_read_ok = (w_elem32 < w_total32);
    assign w_full    = (r_total == CNT_W'(UNIVERSE));

    sis_ram #(.WIDTH(IDX_W), .DEPTH(UNIVERSE)) u_sparse (
        .i_clk   (i_clk),
        .i_we    (sp_we),
        .i_waddr (sp_waddr),
        .i_wdata (sp_wdata),
        .i_re    (sp_re),
        .i_raddr (sp_raddr),
        .o_rdata (sp_rdata)
    );

    sis_ram #(.WIDTH(IDX_W), .DEPTH(UNIVERSE)) u_packed (
        .i_clk   (i_clk),
        .i_we    (pk_we),
        .i_waddr (pk_waddr),
        .i_wdata (pk_wdata),
        .i_re    (pk_re),
        .i_raddr (pk_raddr),
        .o_rdata (pk_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(UNIVERSE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_CHECK;
            ST_CHECK: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Memory accesses and result
    always_comb begin
        sp_re      = 1'b0;
        sp_raddr   = w_in_idx;
        sp_we      = 1'b0;
        sp_waddr   = w_elem_idx;
        sp_wdata   = w_total_idx;
        pk_re      = 1'b0;
        pk_raddr   = w_last_idx;
        pk_we      = 1'b0;
        pk_waddr   = w_total_idx;
        pk_wdata   = w_elem_idx;
        n_clr_addr = r_clr_addr;
        n_pos      = r_pos;
        n_moved    = r_moved;
        n_total    = r_total;
        n_valid    = 1'b0;
        n_was      = r_was;
        n_value    = r_value;
        n_status   = r_status;
        unique case (r_state)
            ST_CLEAR: begin
                // Zero one sparse entry per cycle and advance
                sp_we      = 1'b1;
                sp_waddr   = r_clr_addr;
                sp_wdata   = '0;
                n_clr_addr = r_clr_addr + IDX_W'(1);
            end
            ST_IDLE: begin
                // Read the element's packed position and the last packed entry;
                // a read command fetches the requested position instead
                if (w_accept) begin
                    sp_re = 1'b1;
                    pk_re = 1'b1;
                    if (t_cmd'(i_command) == CMD_READ) begin
                        pk_raddr = w_in_idx;
                    end
                end
            end
            ST_FETCH: begin
                // Hold the fetched data and confirm the packed slot
                n_moved  = pk_rdata;
                n_pos    = sp_rdata;
                pk_re    = 1'b1;
                pk_raddr = sp_rdata;
            end
            ST_CHECK: begin
                n_valid  = 1'b1;
                n_was    = 1'b0;
                n_value  = '0;
                n_status = 1'b0;
                if (r_cmd == CMD_READ) begin
                    if (w_read_ok) begin
                        n_value = w_moved32[VALUE_W-1:0];
                    end else begin
                        n_status = 1'b1;
                    end
                end else if (!w_elem_ok) begin
                    n_status = 1'b1;
                end else begin
                    n_was = w_is_mem;
                    if (r_cmd == CMD_ADD && !w_is_mem && !w_full) begin
                        // Append at the end of the packed table
                        sp_we   = 1'b1;
                        pk_we   = 1'b1;
                        n_total = r_total + CNT_W'(1);
                    end else if (r_cmd == CMD_REMOVE && w_is_mem) begin
                        // Move the last entry into the freed slot
                        pk_we    = 1'b1;
                        pk_waddr = r_pos;
                        pk_wdata = r_moved;
                        sp_we    = 1'b1;
                        sp_waddr = r_moved;
                        sp_wdata = r_pos;
                        n_total  = r_total - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_valid    <= 1'b0;
            r_total    <= '0;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_total    <= n_total;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= t_cmd'(i_command);
            r_elem <= i_element;
        end
        r_pos    <= n_pos;
        r_moved  <= n_moved;
        r_was    <= n_was;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign w_count32      = 32'(r_total);
    assign o_valid        = r_valid;
    assign o_was_member   = r_was;
    assign o_member_count = w_count32[COUNT_W-1:0];
    assign o_read_value   = r_value;
    assign o_status       = r_status;

    // A transferred command always yields a result strobe after its fetch and check
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_valid)
        else $error("result strobe missing after command transfer");

    // The count never passes the universe size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= 32'(UNIVERSE))
        else $error("member count above universe size");

    // Only the check cycle may change the count
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CHECK) |=> $stable(r_total))
        else $error("member count changed outside check cycle");

    // Table writes happen only in the check cycle or the clearing pass
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sp_we || pk_we) |-> (r_state == ST_CHECK || r_state == ST_CLEAR))
        else $error("table write outside check cycle");

    // No new command while a result is being formed
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !w_accept ##1 !w_accept)
        else $error("command transferred while busy");

endmodule

[sim/sparse_integer_set_test.sv]
`timescale 1ns / 1ps

module sparse_integer_set_test;
    import sis_pkg::*;

    localparam int SET_SIZE   = 256;
    localparam int CYCLE_CAP  = 400000;
    localparam int PRINT_CAP  = 50;

    // One result of the set, as the block reports it
    typedef struct packed {
        logic               was_member;
        logic [COUNT_W-1:0] member_count;
        logic [VALUE_W-1:0] read_value;
        logic               status;
    } set_result_t;

    // Keeps a private copy of the set, works out the result of every
    // command that transfers, and checks the results in order.
    class set_tracker;
        int unsigned        sparse_pos [SET_SIZE];
        logic [7:0]         slots      [SET_SIZE];
        logic [COUNT_W-1:0] member_total;
        set_result_t        pending_results [$];
        int unsigned        mismatches;

        function new();
            foreach (sparse_pos[i]) begin
                sparse_pos[i] = 0;
                slots[i]      = '0;
            end
            member_total = '0;
            mismatches   = 0;
        endfunction

        function bit holds(logic [ELEM_W-1:0] e);
            int unsigned pos;
            if (e >= SET_SIZE)
                return 1'b0;
            pos = sparse_pos[e[7:0]];
            return (pos < member_total) && (slots[pos] == e[7:0]);
        endfunction

        function set_result_t apply_command(t_cmd c, logic [ELEM_W-1:0] e);
            set_result_t r;
            int unsigned pos;
            int unsigned last;
            logic [7:0]  moved;
            r = '0;
            if (c == CMD_READ) begin
                if (e < member_total)
                    r.read_value = slots[e];
                else
                    r.status = 1'b1;
            end else if (e >= SET_SIZE) begin
                r.status = 1'b1;
            end else begin
                r.was_member = holds(e);
                if (c == CMD_ADD && !r.was_member && member_total < SET_SIZE) begin
                    sparse_pos[e[7:0]]   = member_total;
                    slots[member_total] = e[7:0];
                    member_total++;
                end else if (c == CMD_REMOVE && r.was_member) begin
                    // fill the hole with the last packed member
                    pos              = sparse_pos[e[7:0]];
                    last             = member_total - 1;
                    moved            = slots[last];
                    slots[pos]       = moved;
                    sparse_pos[moved] = pos;
                    member_total     = COUNT_W'(last);
                end
            end
            r.member_count = member_total;
            return r;
        endfunction

        function void note_command(t_cmd c, logic [ELEM_W-1:0] e);
            pending_results = {pending_results, apply_command(c, e)};
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            if (mismatches < PRINT_CAP)
                $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what,
                         got, want);
            mismatches++;
        endtask

        task check_result(set_result_t got);
            set_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result (count shown)", got.member_count, -1);
                return;
            end
            want = pending_results.pop_front();
            if (got.was_member !== want.was_member)
                report_mismatch("was_member", got.was_member, want.was_member);
            if (got.member_count !== want.member_count)
                report_mismatch("member_count", got.member_count, want.member_count);
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", got.read_value, want.read_value);
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic [ELEM_W-1:0]  i_element;
    logic               o_valid;
    logic               o_was_member;
    logic [COUNT_W-1:0] o_member_count;
    logic [VALUE_W-1:0] o_read_value;
    logic               o_status;

    set_tracker  tracker = new();
    int unsigned idle_pct;
    int unsigned cycle_count;

    sparse_integer_set #(
        .UNIVERSE(SET_SIZE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_element     (i_element),
        .o_valid       (o_valid),
        .o_was_member  (o_was_member),
        .o_member_count(o_member_count),
        .o_read_value  (o_read_value),
        .o_status      (o_status)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stop a hung run; the cap is far above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Take every result in the cycle it is offered; the block cannot be held off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            tracker.check_result({o_was_member, o_member_count, o_read_value, o_status});
    end

    // Present one command from a falling edge and hold it until a rising
    // edge sees busy low; idle first according to idle_pct.
    task automatic send_cmd(t_cmd c, int unsigned e);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= c;
        i_element <= ELEM_W'(e);
        do
            @(posedge i_clk);
        while (busy);
        tracker.note_command(c, ELEM_W'(e));
    endtask

    // Drop start and hold until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mostly in-range values, with a share of out-of-range ones.
    function automatic int unsigned pick_element();
        if ($urandom_range(99) < 8)
            return $urandom_range(511, SET_SIZE);
        return $urandom_range(SET_SIZE - 1);
    endfunction

    // Half the time aim at a current member so removes and tests hit.
    function automatic int unsigned pick_target();
        if (tracker.member_total != 0 && $urandom_range(1))
            return 32'(tracker.slots[$urandom_range(tracker.member_total - 1)]);
        return pick_element();
    endfunction

    function automatic int unsigned pick_position();
        if ($urandom_range(99) < 85)
            return $urandom_range(tracker.member_total);
        return $urandom_range(511);
    endfunction

    task automatic run_random(int unsigned n, int unsigned add_pct, int unsigned remove_pct);
        int unsigned roll;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < add_pct)
                send_cmd(CMD_ADD, pick_element());
            else if (roll < add_pct + remove_pct)
                send_cmd(CMD_REMOVE, pick_target());
            else if (roll % 2 == 0)
                send_cmd(CMD_TEST, pick_target());
            else
                send_cmd(CMD_READ, pick_position());
        end
    endtask

    // Add every element once in shuffled order so the set fills up, then probe
    // the top of the packed table and try an add and a test on the full set.
    task automatic fill_set();
        int unsigned order [SET_SIZE];
        int unsigned j;
        int unsigned tmp;
        foreach (order[i])
            order[i] = i;
        for (int i = SET_SIZE - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
            send_cmd(CMD_ADD, order[i]);
        send_cmd(CMD_READ, SET_SIZE - 1);
        send_cmd(CMD_READ, SET_SIZE);
        send_cmd(CMD_ADD, $urandom_range(SET_SIZE - 1));
        send_cmd(CMD_TEST, $urandom_range(SET_SIZE - 1));
    endtask

    initial begin
        int unsigned phase_idle [3];
        phase_idle  = '{0, 79, 7};
        cycle_count = 0;
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_command   = CMD_ADD;
        i_element   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty set, range limits, duplicates, swap on remove.
        send_cmd(CMD_TEST, 0);
        send_cmd(CMD_READ, 0);        // position past an empty set
        send_cmd(CMD_REMOVE, 7);      // remove of a non-member
        send_cmd(CMD_ADD, 0);
        send_cmd(CMD_ADD, 255);
        send_cmd(CMD_ADD, 0);         // add of an existing member
        send_cmd(CMD_ADD, 256);       // element out of range
        send_cmd(CMD_ADD, 511);
        send_cmd(CMD_TEST, 255);
        send_cmd(CMD_TEST, 511);
        send_cmd(CMD_TEST, 1);
        send_cmd(CMD_READ, 0);
        send_cmd(CMD_READ, 1);
        send_cmd(CMD_READ, 2);        // position at the count
        send_cmd(CMD_READ, 511);
        send_cmd(CMD_REMOVE, 0);      // last member moves into slot 0
        send_cmd(CMD_READ, 0);
        send_cmd(CMD_TEST, 0);        // stale sparse entry must not count
        send_cmd(CMD_TEST, 255);
        send_cmd(CMD_REMOVE, 255);    // remove of the last packed member
        send_cmd(CMD_REMOVE, 255);
        send_cmd(CMD_REMOVE, 511);
        send_cmd(CMD_ADD, 170);
        send_cmd(CMD_ADD, 85);
        send_cmd(CMD_REMOVE, 170);
        drain_results();

        // Random phases: alternate growing and shrinking mixes under
        // different amounts of sender idling; fill the set once.
        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            run_random(150, 60, 10);
            if (p == 0)
                fill_set();
            run_random(150, 15, 50);
            run_random(150, 55, 15);
            run_random(130, 10, 60);
            drain_results();
        end

        // Wait out anything still in the pipeline before judging.
        drain_results();
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sparse_integer_set.f]
src/sis_pkg.sv
src/sis_ram.sv
src/sparse_integer_set.sv
sim/sparse_integer_set_test.sv
